FILE: rtl/rulw_pkg.sv
// rulw_pkg: operation and status codes, field widths and the command and
// status bundles shared by the controller and datapath of the log window
// no dependencies
`default_nettype none

package rulw_pkg;

    localparam int IDX_W  = 64;
    localparam int TERM_W = 64;
    localparam int HDL_W  = 16;
    localparam int FUNC_W = 3;
    localparam int STAT_W = 2;

    // operation selector
    localparam logic [FUNC_W-1:0] FUNC_APPEND      = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_STABLE_TO   = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_STABLE_SNAP = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_RESTORE     = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_LOOKUP      = 3'd4;

    // result status
    localparam logic [STAT_W-1:0] STAT_DONE    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_NOMATCH = 2'd1;
    localparam logic [STAT_W-1:0] STAT_OOB     = 2'd2;
    localparam logic [STAT_W-1:0] STAT_FULL    = 2'd3;

    // controller to datapath, one strobe per step of an operation
    typedef struct packed {
        logic capture;   // latch request payload
        logic calc;      // offset, borrow and end match
        logic addr;      // window hit and ring slot
        logic access;    // ring write and read
        logic finish;    // window update and result
        logic load;      // fill output register
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic out_free;  // output register empty or being taken
    } t_sts;

endpackage

`default_nettype wire

FILE: rtl/rulw_ctrl.sv
// rulw_ctrl: sequencer that steps one request through the window datapath
// depends on rulw_pkg (command and status bundles)
`default_nettype none

module rulw_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    output logic                 o_in_ready,
    input  wire rulw_pkg::t_sts  i_sts,
    output rulw_pkg::t_cmd       o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CALC,
        S_ADDR,
        S_ACCESS,
        S_FINISH,
        S_REPORT
    } t_state;

    t_state r_state;
    logic   r_in_ready;
    logic   take;
    logic   emit;

    assign take = r_in_ready && i_in_valid;
    assign emit = (r_state == S_REPORT) && i_sts.out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_in_ready <= 1'b1;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (take) begin
                        r_state    <= S_CALC;
                        r_in_ready <= 1'b0;
                    end
                end
                S_CALC:   r_state <= S_ADDR;
                S_ADDR:   r_state <= S_ACCESS;
                S_ACCESS: r_state <= S_FINISH;
                S_FINISH: r_state <= S_REPORT;
                S_REPORT: begin
                    if (emit) begin
                        r_state    <= S_IDLE;
                        r_in_ready <= 1'b1;
                    end
                end
                default: begin
                    r_state    <= S_IDLE;
                    r_in_ready <= 1'b1;
                end
            endcase
        end
    end

    assign o_in_ready     = r_in_ready;
    assign o_cmd.capture  = take;
    assign o_cmd.calc     = (r_state == S_CALC);
    assign o_cmd.addr     = (r_state == S_ADDR);
    assign o_cmd.access   = (r_state == S_ACCESS);
    assign o_cmd.finish   = (r_state == S_FINISH);
    assign o_cmd.load     = emit;

endmodule

`default_nettype wire

FILE: rtl/rulw_dp.sv
// rulw_dp: window registers, entry ring memory and output register
// depends on rulw_pkg (codes, widths, command and status bundles)
`default_nettype none

module rulw_dp #(
    parameter int DEPTH = 1024
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire rulw_pkg::t_cmd                i_cmd,
    output rulw_pkg::t_sts                     o_sts,
    input  wire logic [rulw_pkg::FUNC_W-1:0]   i_func,
    input  wire logic [rulw_pkg::IDX_W-1:0]    i_index,
    input  wire logic [rulw_pkg::TERM_W-1:0]   i_term,
    input  wire logic [rulw_pkg::HDL_W-1:0]    i_handle,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic [rulw_pkg::STAT_W-1:0]        o_status,
    output logic [rulw_pkg::TERM_W-1:0]        o_found_term,
    output logic [rulw_pkg::HDL_W-1:0]         o_found_handle,
    output logic [rulw_pkg::IDX_W-1:0]         o_first_index,
    output logic                               o_first_valid,
    output logic [rulw_pkg::IDX_W-1:0]         o_last_index,
    output logic                               o_last_valid
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int IW = rulw_pkg::IDX_W;
    localparam int TW = rulw_pkg::TERM_W;
    localparam int HW = rulw_pkg::HDL_W;

    // captured request
    logic [rulw_pkg::FUNC_W-1:0] r_func;
    logic [IW-1:0]               r_idx;
    logic [TW-1:0]               r_term;
    logic [HW-1:0]               r_hdl;

    // window state; r_sslot is the ring slot of window_start
    logic [IW-1:0] r_ws, n_ws;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [AW-1:0] r_sslot, n_sslot;
    logic          r_snap_held, n_snap_held;
    logic [IW-1:0] r_snap_idx, n_snap_idx;
    logic [TW-1:0] r_snap_term, n_snap_term;

    // per request working values
    logic [IW-1:0] r_diff;
    logic          r_below;
    logic          r_at_end;
    logic          r_in_win;
    logic          r_le;
    logic [AW-1:0] r_slot;

    // ring
    logic [TW-1:0] r_term_mem [DEPTH];
    logic [HW-1:0] r_hdl_mem  [DEPTH];
    logic [TW-1:0] r_rd_term;
    logic [HW-1:0] r_rd_hdl;

    // result of the finish step
    logic [rulw_pkg::STAT_W-1:0] r_res_status, n_res_status;
    logic [TW-1:0]               r_res_ft, n_res_ft;
    logic [HW-1:0]               r_res_fh, n_res_fh;

    // output register
    logic                        r_out_valid;
    logic [rulw_pkg::STAT_W-1:0] r_o_status;
    logic [TW-1:0]               r_o_ft;
    logic [HW-1:0]               r_o_fh;
    logic [IW-1:0]               r_o_first;
    logic                        r_o_first_valid;
    logic [IW-1:0]               r_o_last;
    logic                        r_o_last_valid;

    logic [IW:0]   diff_ext;
    logic [AW:0]   slot_sum;
    logic [AW-1:0] slot_wrapped;
    logic [AW-1:0] slot_next;
    logic          full;
    logic          wr_en;
    logic [AW-1:0] wr_slot;

    assign full = (r_cnt == CW'(DEPTH));

    // request capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_func <= i_func;
            r_idx  <= i_index;
            r_term <= i_term;
            r_hdl  <= i_handle;
        end
    end

    // offset from window start, borrow gives "below start"
    assign diff_ext = {1'b0, r_idx} - {1'b0, r_ws};

    // offset plus slot of start, folded once into the ring
    assign slot_sum     = {1'b0, r_diff[AW-1:0]} + {1'b0, r_sslot};
    assign slot_wrapped = (slot_sum >= (AW+1)'(DEPTH)) ?
                          AW'(slot_sum - (AW+1)'(DEPTH)) : slot_sum[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.calc) begin
            r_diff   <= diff_ext[IW-1:0];
            r_below  <= diff_ext[IW];
            r_at_end <= (r_idx == (r_ws + IW'(r_cnt)));
        end
        if (i_cmd.addr) begin
            r_in_win <= !r_below && (r_diff[IW-1:CW] == '0) && (r_diff[CW-1:0] < r_cnt);
            r_le     <= r_below || (r_diff == '0);
            r_slot   <= slot_wrapped;
        end
    end

    // ring write for appends; a replaced window restarts at slot zero
    always_comb begin
        wr_en   = 1'b0;
        wr_slot = r_slot;
        if (r_func == rulw_pkg::FUNC_APPEND) begin
            if (r_at_end) begin
                wr_en = !full;
            end else if (r_le) begin
                wr_en   = 1'b1;
                wr_slot = '0;
            end else if (r_in_win) begin
                wr_en = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.access) begin
            if (wr_en) begin
                r_term_mem[wr_slot] <= r_term;
                r_hdl_mem[wr_slot]  <= r_hdl;
            end
            r_rd_term <= r_term_mem[r_slot];
            r_rd_hdl  <= r_hdl_mem[r_slot];
        end
    end

    assign slot_next = (r_slot == AW'(DEPTH - 1)) ? '0 : r_slot + 1'b1;

    // window update and result
    always_comb begin
        n_ws         = r_ws;
        n_cnt        = r_cnt;
        n_sslot      = r_sslot;
        n_snap_held  = r_snap_held;
        n_snap_idx   = r_snap_idx;
        n_snap_term  = r_snap_term;
        n_res_status = rulw_pkg::STAT_NOMATCH;
        n_res_ft     = '0;
        n_res_fh     = '0;
        case (r_func)
            rulw_pkg::FUNC_APPEND: begin
                if (r_at_end) begin
                    if (full) begin
                        n_res_status = rulw_pkg::STAT_FULL;
                    end else begin
                        n_cnt        = r_cnt + 1'b1;
                        n_res_status = rulw_pkg::STAT_DONE;
                    end
                end else if (r_le) begin
                    n_ws         = r_idx;
                    n_cnt        = CW'(1);
                    n_sslot      = '0;
                    n_res_status = rulw_pkg::STAT_DONE;
                end else if (r_in_win) begin
                    n_cnt        = r_diff[CW-1:0] + 1'b1;
                    n_res_status = rulw_pkg::STAT_DONE;
                end else begin
                    n_res_status = rulw_pkg::STAT_OOB;
                end
            end
            rulw_pkg::FUNC_STABLE_TO: begin
                if (r_in_win && (r_rd_term == r_term)) begin
                    n_cnt        = r_cnt - r_diff[CW-1:0] - 1'b1;
                    n_ws         = r_idx + 1'b1;
                    n_sslot      = slot_next;
                    n_res_status = rulw_pkg::STAT_DONE;
                end
            end
            rulw_pkg::FUNC_STABLE_SNAP: begin
                if (r_snap_held && (r_snap_idx == r_idx)) begin
                    n_snap_held  = 1'b0;
                    n_res_status = rulw_pkg::STAT_DONE;
                end
            end
            rulw_pkg::FUNC_RESTORE: begin
                n_ws         = r_idx + 1'b1;
                n_cnt        = '0;
                n_sslot      = '0;
                n_snap_held  = 1'b1;
                n_snap_idx   = r_idx;
                n_snap_term  = r_term;
                n_res_status = rulw_pkg::STAT_DONE;
            end
            rulw_pkg::FUNC_LOOKUP: begin
                if (r_below) begin
                    if (r_snap_held && (r_snap_idx == r_idx)) begin
                        n_res_ft     = r_snap_term;
                        n_res_status = rulw_pkg::STAT_DONE;
                    end
                end else if (r_in_win) begin
                    n_res_ft     = r_rd_term;
                    n_res_fh     = r_rd_hdl;
                    n_res_status = rulw_pkg::STAT_DONE;
                end
            end
            default: begin
                n_res_status = rulw_pkg::STAT_NOMATCH;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ws        <= '0;
            r_cnt       <= '0;
            r_sslot     <= '0;
            r_snap_held <= 1'b0;
            r_snap_idx  <= '0;
            r_snap_term <= '0;
        end else if (i_cmd.finish) begin
            r_ws        <= n_ws;
            r_cnt       <= n_cnt;
            r_sslot     <= n_sslot;
            r_snap_held <= n_snap_held;
            r_snap_idx  <= n_snap_idx;
            r_snap_term <= n_snap_term;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_res_status <= n_res_status;
            r_res_ft     <= n_res_ft;
            r_res_fh     <= n_res_fh;
        end
    end

    // output register, first and last index from the updated window
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_o_status      <= r_res_status;
            r_o_ft          <= r_res_ft;
            r_o_fh          <= r_res_fh;
            r_o_first       <= r_snap_held ? r_snap_idx + 1'b1 : '0;
            r_o_first_valid <= r_snap_held;
            if (r_cnt != '0) begin
                r_o_last <= r_ws + IW'(r_cnt) - 1'b1;
            end else if (r_snap_held) begin
                r_o_last <= r_snap_idx;
            end else begin
                r_o_last <= '0;
            end
            r_o_last_valid  <= (r_cnt != '0) || r_snap_held;
        end
    end

    assign o_sts.out_free = !r_out_valid || i_out_ready;

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_o_status;
    assign o_found_term   = r_o_ft;
    assign o_found_handle = r_o_fh;
    assign o_first_index  = r_o_first;
    assign o_first_valid  = r_o_first_valid;
    assign o_last_index   = r_o_last;
    assign o_last_valid   = r_o_last_valid;

endmodule

`default_nettype wire

FILE: rtl/raft_unstable_log_window.sv
// raft_unstable_log_window: top level of the unpersisted log window
// depends on rulw_pkg, rulw_ctrl and rulw_dp
`default_nettype none

//  channel   direction  handshake                   payload
//  request   in         i_in_valid / o_in_ready     i_func i_index i_term i_handle
//  result    out        o_out_valid / i_out_ready   o_status o_found_term o_found_handle
//                                                   o_first_index o_first_valid
//                                                   o_last_index o_last_valid
//
//  each request passes from accept to the next accept through the calc, addr,
//  ring access, finish and report steps of the sequencer
//  the ring has one write and one registered read port, each used at most once per request
//  a result that is not taken holds the report step, new requests wait behind it
//  synchronous active-low reset empties the window and drops the snapshot;
//  ring contents are not cleared, only reads of slots inside the window are used

module raft_unstable_log_window #(
    parameter int DEPTH = 1024
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // request channel
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic [rulw_pkg::FUNC_W-1:0]   i_func,
    input  wire logic [rulw_pkg::IDX_W-1:0]    i_index,
    input  wire logic [rulw_pkg::TERM_W-1:0]   i_term,
    input  wire logic [rulw_pkg::HDL_W-1:0]    i_handle,
    // result channel
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic [rulw_pkg::STAT_W-1:0]        o_status,
    output logic [rulw_pkg::TERM_W-1:0]        o_found_term,
    output logic [rulw_pkg::HDL_W-1:0]         o_found_handle,
    output logic [rulw_pkg::IDX_W-1:0]         o_first_index,
    output logic                               o_first_valid,
    output logic [rulw_pkg::IDX_W-1:0]         o_last_index,
    output logic                               o_last_valid
);

    // step strobes out of the sequencer, output-register status back in
    rulw_pkg::t_cmd cmd;
    rulw_pkg::t_sts sts;

    rulw_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // window registers, ring and the result register
    rulw_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_func         (i_func),
        .i_index        (i_index),
        .i_term         (i_term),
        .i_handle       (i_handle),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_status       (o_status),
        .o_found_term   (o_found_term),
        .o_found_handle (o_found_handle),
        .o_first_index  (o_first_index),
        .o_first_valid  (o_first_valid),
        .o_last_index   (o_last_index),
        .o_last_valid   (o_last_valid)
    );

endmodule

`default_nettype wire

FILE: rtl/rulw_checker.sv
// rulw_checker: port-level checks of the log window and their bind
// depends on rulw_pkg and the top level raft_unstable_log_window
`default_nettype none

module rulw_checker (
    input wire logic                        i_clk,
    input wire logic                        i_rst_n,
    input wire logic                        i_in_valid,
    input wire logic                        o_in_ready,
    input wire logic                        o_out_valid,
    input wire logic                        i_out_ready,
    input wire logic [rulw_pkg::STAT_W-1:0] o_status,
    input wire logic [rulw_pkg::IDX_W-1:0]  o_first_index,
    input wire logic                        o_first_valid,
    input wire logic [rulw_pkg::IDX_W-1:0]  o_last_index,
    input wire logic                        o_last_valid
);

    // a stalled result keeps its status
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_status))
        else $error("result dropped or changed while stalled");

    // one request in flight: no new request taken right after one is accepted
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("second request taken while one is in flight");

    // a held snapshot always counts as a last index
    a_first_implies_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_first_valid |-> o_last_valid)
        else $error("first index valid without last index");

    // empty log reports zero indexes
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_last_valid |-> o_last_index == '0 && o_first_index == '0)
        else $error("empty log reports nonzero index");

endmodule

bind raft_unstable_log_window rulw_checker u_rulw_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_ready    (o_in_ready),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_status      (o_status),
    .o_first_index (o_first_index),
    .o_first_valid (o_first_valid),
    .o_last_index  (o_last_index),
    .o_last_valid  (o_last_valid)
);

`default_nettype wire
